// ===== rtl/core/base_composition_window_filter_defines.svh =====
// Assertion macros shared by the base composition window filter RTL.
// Included by each module that checks its own invariants; no other dependencies.
`ifndef BASE_COMPOSITION_WINDOW_FILTER_DEFINES_SVH
`define BASE_COMPOSITION_WINDOW_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// Combinational invariant that must hold at every clock edge outside reset.
`define BCWF_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bcwf: invariant violated");
// Condition that must hold in the cycle after the antecedent.
`define BCWF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcwf: next-cycle check violated");
`else
`define BCWF_ASSERT(label, clk, rst, expr)
`define BCWF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/bcwf_pkg.sv =====
// Types, constants and width helpers for the base composition window filter.
// No dependencies; used by every module of the block.
package bcwf_pkg;

   // Field widths of the configuration registers.
   localparam int CFG_W   = 7;
   localparam int LIMIT_W = 8;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Four counting lanes, in the order A, C, G, T (base codes 0 to 3).
   localparam int LANE_COUNT = 4;

   // Code for any base that is not A, C, G or T.
   localparam logic [2:0] BASE_OTHER = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd0;
   localparam logic [2:0] REG_QUERY_COUNT_A  = 3'd1;
   localparam logic [2:0] REG_QUERY_COUNT_C  = 3'd2;
   localparam logic [2:0] REG_QUERY_COUNT_G  = 3'd3;
   localparam logic [2:0] REG_QUERY_COUNT_T  = 3'd4;
   localparam logic [2:0] REG_DISTANCE_LIMIT = 3'd5;

   // Control that travels with an item from the window store to the count lanes.
   typedef struct packed {
      logic       remove;     // a base leaves the window
      logic       read_last;  // final base of the read
      logic [2:0] base_code;  // entering base, already clamped
   } slot_ctl_type;

   // Bits for a value from 0 to max_window inclusive.
   function automatic int count_width(input int max_window);
      return $clog2(max_window + 1);
   endfunction

   // Bits for one absolute difference between a count and a query count.
   function automatic int diff_width(input int max_window);
      return (count_width(max_window) > CFG_W) ? count_width(max_window) : CFG_W;
   endfunction

   // Bits for the sum of four differences, never narrower than the limit.
   function automatic int sum_width(input int max_window);
      return ((diff_width(max_window) + 2) > LIMIT_W) ? (diff_width(max_window) + 2) : LIMIT_W;
   endfunction

endpackage

// ===== rtl/core/base_composition_window_filter.sv =====
// Top level of the base composition window filter: configuration registers,
// distance compare, sticky match flag and result register.
// Depends on bcwf_pkg, bcwf_window_store, bcwf_count_lanes and the assertion macros.
//
// Usage: one DNA base enters per item on the req_ channel (base_code 0=A, 1=C,
// 2=G, 3=T, anything else counts as other; read_last marks a read's final base).
// Each item yields exactly one result item on the rsp_ channel: window_hit for
// this position, read_matched as the running answer for the read, and read_end
// echoing read_last so that the result carrying it holds the read's verdict.
// Throughput is one item per clock while the receiver keeps rsp_ready high. The
// pipeline is store read, count update with per-lane differences, then sum and
// compare into the result register. The window store is one memory written and
// read once per item, so one base a cycle is the limit. When the receiver
// stalls, the two internal stages keep accepting until they fill, then req_ready
// drops; nothing is lost or repeated. Reset clears pointers, counts, the match
// flag and the valid bits and loads the register defaults; the base store needs
// no clearing, since only slots written during the current read are ever read
// back. The user must write configuration over the csr_ port only while the
// block is idle; the block itself does not enforce it.
`include "base_composition_window_filter_defines.svh"

module base_composition_window_filter #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input items
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_base_code,
   input  logic                             req_read_last,
   // Result items
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_window_hit,
   output logic                             rsp_read_matched,
   output logic                             rsp_read_end,
   // Configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bcwf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bcwf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bcwf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import bcwf_pkg::*;

   localparam int LenW  = $clog2(MAX_WINDOW + 1);
   localparam int ExtW  = (LenW > CFG_W) ? LenW : CFG_W;
   localparam int DiffW = diff_width(MAX_WINDOW);
   localparam int SumW  = sum_width(MAX_WINDOW);

   logic [CFG_W-1:0]                  window_length_ff;
   logic [LANE_COUNT-1:0][CFG_W-1:0]  query_ff;
   logic [LIMIT_W-1:0]                limit_ff;
   logic [2:0]                        csr_index;
   logic                              csr_write;
   logic [ExtW-1:0]                   len_ext;
   logic [LenW-1:0]                   win_len;

   logic                              req_accept;
   logic                              s1_valid;
   logic                              s2_valid;
   logic                              s2_last;
   logic                              take;
   logic                              take2;
   logic                              stage2_free;
   logic [2:0]                        old_base;
   slot_ctl_type                      ctl;
   logic [LANE_COUNT-1:0][DiffW-1:0]  diffs;

   logic [SumW-1:0]                   distance;
   logic                              hit;
   logic                              matched;
   logic                              matched_ff, matched_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              hit_ff;
   logic                              rsp_matched_ff;
   logic                              rsp_end_ff;

   // Configuration register writes on the access phase.
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= CFG_W'(42);
         query_ff[0]      <= CFG_W'(20);
         query_ff[1]      <= CFG_W'(8);
         query_ff[2]      <= CFG_W'(10);
         query_ff[3]      <= CFG_W'(4);
         limit_ff         <= LIMIT_W'(3);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH:  window_length_ff <= csr_pwdata[CFG_W-1:0];
            REG_QUERY_COUNT_A:  query_ff[0]      <= csr_pwdata[CFG_W-1:0];
            REG_QUERY_COUNT_C:  query_ff[1]      <= csr_pwdata[CFG_W-1:0];
            REG_QUERY_COUNT_G:  query_ff[2]      <= csr_pwdata[CFG_W-1:0];
            REG_QUERY_COUNT_T:  query_ff[3]      <= csr_pwdata[CFG_W-1:0];
            REG_DISTANCE_LIMIT: limit_ff         <= csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_WINDOW_LENGTH:  csr_prdata = CSR_DATA_W'(window_length_ff);
         REG_QUERY_COUNT_A:  csr_prdata = CSR_DATA_W'(query_ff[0]);
         REG_QUERY_COUNT_C:  csr_prdata = CSR_DATA_W'(query_ff[1]);
         REG_QUERY_COUNT_G:  csr_prdata = CSR_DATA_W'(query_ff[2]);
         REG_QUERY_COUNT_T:  csr_prdata = CSR_DATA_W'(query_ff[3]);
         REG_DISTANCE_LIMIT: csr_prdata = CSR_DATA_W'(limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Window length in use: zero acts as one, and it never exceeds the store.
   assign len_ext = ExtW'(window_length_ff);
   always_comb begin
      priority if (len_ext == '0) begin
         win_len = LenW'(1);
      end else if (len_ext > ExtW'(MAX_WINDOW)) begin
         win_len = LenW'(MAX_WINDOW);
      end else begin
         win_len = LenW'(len_ext);
      end
   end

   // Pipeline flow: each stage moves on when the one after it is free.
   assign take2       = s2_valid & (~rsp_valid_ff | rsp_ready);
   assign stage2_free = ~s2_valid | take2;
   assign take        = s1_valid & stage2_free;
   assign req_ready   = ~s1_valid | stage2_free;
   assign req_accept  = req_valid & req_ready;

   bcwf_window_store #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .take      (take),
      .win_len   (win_len),
      .base_code (req_base_code),
      .read_last (req_read_last),
      .s1_valid  (s1_valid),
      .old_base  (old_base),
      .ctl       (ctl)
   );

   bcwf_count_lanes #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_lanes (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .take2        (take2),
      .old_base     (old_base),
      .ctl          (ctl),
      .query_counts (query_ff),
      .s2_valid     (s2_valid),
      .s2_last      (s2_last),
      .diffs        (diffs)
   );

   // Composition distance and the hit compare.
   assign distance = SumW'(diffs[0]) + SumW'(diffs[1]) + SumW'(diffs[2]) + SumW'(diffs[3]);
   assign hit      = (distance < SumW'(limit_ff));
   assign matched  = matched_ff | hit;

   // The sticky flag clears once the read's final item has been scored.
   always_comb begin
      matched_in = matched_ff;
      if (take2) begin
         matched_in = s2_last ? 1'b0 : matched;
      end
   end

   assign rsp_valid_in = take2 | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (take2) begin
         hit_ff         <= hit;
         rsp_matched_ff <= matched;
         rsp_end_ff     <= s2_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_hit   = hit_ff;
   assign rsp_read_matched = rsp_matched_ff;
   assign rsp_read_end     = rsp_end_ff;

   `BCWF_ASSERT_NEXT(accept_fills_stage, clock, reset, req_accept, s1_valid)
   `BCWF_ASSERT_NEXT(flag_clear_after_read, clock, reset, take2 && s2_last, !matched_ff)

endmodule

// ===== rtl/core/bcwf_window_store.sv =====
// Circular base store with write slot and fill count; reads the leaving base.
// Depends on bcwf_pkg and the block's assertion macros.
`include "base_composition_window_filter_defines.svh"

module bcwf_window_store #(
   parameter int MAX_WINDOW = 64,
   localparam int AddrW = $clog2(MAX_WINDOW),
   localparam int LenW  = $clog2(MAX_WINDOW + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    take,
   input  logic [LenW-1:0]         win_len,
   input  logic [2:0]              base_code,
   input  logic                    read_last,
   output logic                    s1_valid,
   output logic [2:0]              old_base,
   output bcwf_pkg::slot_ctl_type  ctl
);
   import bcwf_pkg::*;

   localparam int XW = LenW + 1;

   logic [2:0]       mem [MAX_WINDOW];
   logic [AddrW-1:0] write_slot_ff, write_slot_in;
   logic [LenW-1:0]  bases_seen_ff, bases_seen_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [2:0]       old_base_ff;
   slot_ctl_type     ctl_ff, ctl_in;
   logic [XW-1:0]    slot_ext;
   logic [XW-1:0]    len_ext;
   logic [AddrW-1:0] old_slot;
   logic [2:0]       code_clamped;

   // Codes above "other" count as other.
   assign code_clamped = (base_code > BASE_OTHER) ? BASE_OTHER : base_code;

   // Slot of the base window_length positions back, wrapped once.
   assign slot_ext = XW'(write_slot_ff);
   assign len_ext  = XW'(win_len);
   always_comb begin
      if (slot_ext >= len_ext) begin
         old_slot = AddrW'(slot_ext - len_ext);
      end else begin
         old_slot = AddrW'(slot_ext + XW'(MAX_WINDOW) - len_ext);
      end
   end

   // Pointer and fill count advance per accepted item and clear after a read.
   always_comb begin
      write_slot_in = write_slot_ff;
      bases_seen_in = bases_seen_ff;
      if (accept) begin
         if (read_last) begin
            write_slot_in = '0;
            bases_seen_in = '0;
         end else begin
            write_slot_in = (write_slot_ff == AddrW'(MAX_WINDOW - 1)) ? '0
                          : write_slot_ff + AddrW'(1);
            bases_seen_in = (bases_seen_ff < LenW'(MAX_WINDOW))
                          ? bases_seen_ff + LenW'(1) : bases_seen_ff;
         end
      end
   end

   // The stage holds its item until the count lanes take it.
   assign s1_valid_in      = accept | (s1_valid_ff & ~take);
   assign ctl_in.remove    = (bases_seen_ff >= win_len);
   assign ctl_in.read_last = read_last;
   assign ctl_in.base_code = code_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         bases_seen_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         write_slot_ff <= write_slot_in;
         bases_seen_ff <= bases_seen_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   // Item control; payload only, no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff <= ctl_in;
      end
   end

   // Read-first memory: the leaving base is read before the new one lands.
   always_ff @(posedge clock) begin
      if (accept) begin
         old_base_ff         <= mem[old_slot];
         mem[write_slot_ff]  <= code_clamped;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign old_base = old_base_ff;
   assign ctl      = ctl_ff;

   `BCWF_ASSERT(seen_bounded, clock, reset, bases_seen_ff <= LenW'(MAX_WINDOW))
   `BCWF_ASSERT(slot_bounded, clock, reset, write_slot_ff <= AddrW'(MAX_WINDOW - 1))

endmodule

// ===== rtl/core/bcwf_count_lanes.sv =====
// Four saturating base counters (A, C, G, T) and their distances to the query.
// Depends on bcwf_pkg and the block's assertion macros.
`include "base_composition_window_filter_defines.svh"

module bcwf_count_lanes #(
   parameter int MAX_WINDOW = 64,
   localparam int DiffW = bcwf_pkg::diff_width(MAX_WINDOW)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic                    take2,
   input  logic [2:0]              old_base,
   input  bcwf_pkg::slot_ctl_type  ctl,
   input  logic [bcwf_pkg::LANE_COUNT-1:0][bcwf_pkg::CFG_W-1:0] query_counts,
   output logic                    s2_valid,
   output logic                    s2_last,
   output logic [bcwf_pkg::LANE_COUNT-1:0][DiffW-1:0] diffs
);
   import bcwf_pkg::*;

   localparam int CountW = count_width(MAX_WINDOW);

   logic [LANE_COUNT-1:0][CountW-1:0] counts_ff, counts_in;
   logic [LANE_COUNT-1:0][CountW-1:0] lane_val;
   logic [LANE_COUNT-1:0][DiffW-1:0]  lane_cnt;
   logic [LANE_COUNT-1:0][DiffW-1:0]  lane_qry;
   logic [LANE_COUNT-1:0][DiffW-1:0]  diff_ff, diff_in;
   logic                              s2_valid_ff, s2_valid_in;
   logic                              s2_last_ff;

   // Per lane: drop the leaving base, add the entering one, both saturating.
   always_comb begin
      for (int k = 0; k < LANE_COUNT; k++) begin
         lane_val[k] = counts_ff[k];
         if (ctl.remove && (old_base == 3'(k)) && (counts_ff[k] != '0)) begin
            lane_val[k] = counts_ff[k] - CountW'(1);
         end
         if ((ctl.base_code == 3'(k)) && (lane_val[k] != CountW'(MAX_WINDOW))) begin
            lane_val[k] = lane_val[k] + CountW'(1);
         end
         lane_cnt[k]  = DiffW'(lane_val[k]);
         lane_qry[k]  = DiffW'(query_counts[k]);
         diff_in[k]   = (lane_cnt[k] > lane_qry[k]) ? lane_cnt[k] - lane_qry[k]
                                                    : lane_qry[k] - lane_cnt[k];
         counts_in[k] = ctl.read_last ? '0 : lane_val[k];
      end
   end

   assign s2_valid_in = take | (s2_valid_ff & ~take2);

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff   <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (take) begin
            counts_ff <= counts_in;
         end
      end
   end

   // Differences travel with the item to the distance stage.
   always_ff @(posedge clock) begin
      if (take) begin
         diff_ff    <= diff_in;
         s2_last_ff <= ctl.read_last;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_last  = s2_last_ff;
   assign diffs    = diff_ff;

   `BCWF_ASSERT_NEXT(clear_after_last, clock, reset, take && ctl.read_last, counts_ff == '0)

endmodule

// ===== test/base_composition_window_filter_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the base composition window filter: directed and random base
// streams, with each result item checked against a sliding-window predictor.
// Depends on bcwf_pkg and the base_composition_window_filter RTL.
module base_composition_window_filter_tb;

   localparam int WINDOW_SLOTS = 64;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BASES = 750;
   localparam int SHOWN_ERRORS = 10;

   // Base codes as they arrive on the input channel.
   localparam logic [2:0] BASE_A        = 3'd0;
   localparam logic [2:0] BASE_C        = 3'd1;
   localparam logic [2:0] BASE_G        = 3'd2;
   localparam logic [2:0] BASE_T        = 3'd3;
   localparam logic [2:0] BASE_OTHER    = bcwf_pkg::BASE_OTHER;
   localparam logic [2:0] BASE_CODE_MAX = 3'd7;

   // Fields of one result item.
   typedef struct packed {
      logic window_hit;
      logic read_matched;
      logic read_end;
   } verdict_type;

   // Tracks the window composition of the current read and checks each verdict.
   class composition_scoreboard_type;
      logic [6:0]  window_length;
      logic [6:0]  query_count [bcwf_pkg::LANE_COUNT];
      logic [7:0]  distance_limit;
      logic [2:0]  window_bases [WINDOW_SLOTS];
      logic [5:0]  write_slot;
      logic [6:0]  bases_seen;
      logic [6:0]  window_counts [bcwf_pkg::LANE_COUNT];
      logic        matched_flag;
      verdict_type awaited_verdicts [$];
      int          errors;

      function new();
         window_length  = 7'd42;
         query_count    = '{7'd20, 7'd8, 7'd10, 7'd4};
         distance_limit = 8'd3;
         foreach (window_bases[i]) window_bases[i] = BASE_A;
         errors = 0;
         clear_read();
      endfunction

      function void clear_read();
         write_slot   = '0;
         bases_seen   = '0;
         foreach (window_counts[i]) window_counts[i] = '0;
         matched_flag = 1'b0;
      endfunction

      // Every failure is counted; only the first few are shown.
      function void report(string msg);
         errors++;
         if (errors <= SHOWN_ERRORS) $display("%s", msg);
      endfunction

      function void set_register(logic [2:0] index, logic [31:0] value);
         case (index)
            bcwf_pkg::REG_WINDOW_LENGTH:  window_length  = value[6:0];
            bcwf_pkg::REG_QUERY_COUNT_A:  query_count[0] = value[6:0];
            bcwf_pkg::REG_QUERY_COUNT_C:  query_count[1] = value[6:0];
            bcwf_pkg::REG_QUERY_COUNT_G:  query_count[2] = value[6:0];
            bcwf_pkg::REG_QUERY_COUNT_T:  query_count[3] = value[6:0];
            bcwf_pkg::REG_DISTANCE_LIMIT: distance_limit = value[7:0];
            default: ;
         endcase
      endfunction

      // Slides the window by one accepted base and queues the verdict it yields.
      function void note_base(logic [2:0] code, logic last);
         int          span;
         int          leaving;
         int          distance_sum;
         logic [2:0]  entering;
         verdict_type v;
         span = (window_length == 0) ? 1 :
                (window_length > WINDOW_SLOTS) ? WINDOW_SLOTS : int'(window_length);
         entering = (code > BASE_OTHER) ? BASE_OTHER : code;

         // Once the read fills the window, the base span positions back drops out.
         if (bases_seen >= span) begin
            leaving = window_bases[(int'(write_slot) + WINDOW_SLOTS - span) % WINDOW_SLOTS];
            if (leaving < bcwf_pkg::LANE_COUNT && window_counts[leaving] > 0)
               window_counts[leaving]--;
         end

         window_bases[write_slot] = entering;
         write_slot = write_slot + 6'd1;
         if (bases_seen < WINDOW_SLOTS) bases_seen++;
         if (entering != BASE_OTHER && window_counts[entering[1:0]] < WINDOW_SLOTS)
            window_counts[entering[1:0]]++;

         // Composition distance: sum of absolute count differences per lane.
         distance_sum = 0;
         for (int lane = 0; lane < bcwf_pkg::LANE_COUNT; lane++) begin
            if (window_counts[lane] > query_count[lane])
               distance_sum += int'(window_counts[lane]) - int'(query_count[lane]);
            else
               distance_sum += int'(query_count[lane]) - int'(window_counts[lane]);
         end

         v.window_hit   = (distance_sum < int'(distance_limit));
         matched_flag   = matched_flag | v.window_hit;
         v.read_matched = matched_flag;
         v.read_end     = last;
         awaited_verdicts.insert(awaited_verdicts.size(), v);
         if (last) clear_read();
      endfunction

      function void check_result(logic hit, logic matched, logic ending);
         verdict_type want;
         if (awaited_verdicts.size() == 0) begin
            report($sformatf("unexpected result item: hit=%0b matched=%0b end=%0b",
                             hit, matched, ending));
         end else begin
            want = awaited_verdicts.pop_front();
            if (hit !== want.window_hit || matched !== want.read_matched ||
                ending !== want.read_end)
               report($sformatf({"result mismatch: expected hit=%0b matched=%0b end=%0b,",
                                 " got hit=%0b matched=%0b end=%0b"},
                                want.window_hit, want.read_matched, want.read_end,
                                hit, matched, ending));
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [2:0]                      req_base_code = BASE_A;
   logic                            req_read_last = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_window_hit;
   logic                            rsp_read_matched;
   logic                            rsp_read_end;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [bcwf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [bcwf_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [bcwf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   logic                            steady_traffic = 1'b0;
   int                              bases_sent = 0;
   int                              cycle_count = 0;
   composition_scoreboard_type      sb;

   base_composition_window_filter #(.MAX_WINDOW(WINDOW_SLOTS)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_base_code    (req_base_code),
      .req_read_last    (req_read_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_hit   (rsp_window_hit),
      .rsp_read_matched (rsp_read_matched),
      .rsp_read_end     (rsp_read_end),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: check each accepted item, then choose the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_window_hit, rsp_read_matched, rsp_read_end);
      rsp_ready <= steady_traffic || ($urandom_range(99) >= 13);
   end

   // Hard stop in case the block hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Offers one base and holds it until the block takes it.
   task automatic send_base(input logic [2:0] code, input logic last);
      if (!steady_traffic && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_base_code <= code;
      req_read_last <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_base(code, last);
      bases_sent++;
   endtask

   // Stops offering and waits until every queued verdict has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.awaited_verdicts.size() != 0) @(posedge clock);
   endtask

   // Writes one register with junk above the field, then reads it back.
   task automatic write_register(input logic [2:0] index, input logic [7:0] value);
      logic [31:0] field_mask;
      logic [31:0] data;
      logic [31:0] readback;
      field_mask = (index == bcwf_pkg::REG_DISTANCE_LIMIT) ? 32'hFF : 32'h7F;
      data = ($urandom() & ~field_mask) | ({24'd0, value} & field_mask);

      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(index, data);

      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== (data & field_mask))
         sb.report($sformatf("register %0d read back %h, expected %h",
                             index, readback, data & field_mask));
   endtask

   task automatic load_setting(input int span, input int qa, input int qc, input int qg,
                               input int qt, input int limit);
      write_register(bcwf_pkg::REG_WINDOW_LENGTH, 8'(span));
      write_register(bcwf_pkg::REG_QUERY_COUNT_A, 8'(qa));
      write_register(bcwf_pkg::REG_QUERY_COUNT_C, 8'(qc));
      write_register(bcwf_pkg::REG_QUERY_COUNT_G, 8'(qg));
      write_register(bcwf_pkg::REG_QUERY_COUNT_T, 8'(qt));
      write_register(bcwf_pkg::REG_DISTANCE_LIMIT, 8'(limit));
   endtask

   // Draws a base roughly in the query proportions so that windows can match.
   function automatic logic [2:0] pick_base();
      int total;
      int weight;
      int r;
      total = 0;
      for (int lane = 0; lane < bcwf_pkg::LANE_COUNT; lane++)
         total += (sb.query_count[lane] > WINDOW_SLOTS) ? WINDOW_SLOTS : sb.query_count[lane];
      if (total == 0 || $urandom_range(19) == 0)
         return 3'($urandom_range(BASE_OTHER, BASE_CODE_MAX));
      r = $urandom_range(total - 1);
      for (int lane = 0; lane < bcwf_pkg::LANE_COUNT; lane++) begin
         weight = (sb.query_count[lane] > WINDOW_SLOTS) ? WINDOW_SLOTS : sb.query_count[lane];
         if (r < weight) return 3'(lane);
         r -= weight;
      end
      return BASE_OTHER;
   endfunction

   // Streams one read; a noisy read uses uniform codes, an open one has no end mark.
   task automatic stream_read(input int length, input bit noisy, input bit closes);
      logic [2:0] code;
      for (int i = 0; i < length; i++) begin
         code = noisy ? 3'($urandom_range(BASE_CODE_MAX)) : pick_base();
         send_base(code, closes && (i == length - 1));
      end
   endtask

   initial begin
      int phase;
      int random_goal;
      int span;
      int span_used;
      int qa;
      int qc;
      int qg;
      int limit;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Two bases under the reset defaults; the read ends on the highest code.
      send_base(BASE_A, 1'b0);
      send_base(BASE_CODE_MAX, 1'b1);
      drain_results();

      // A four-base window that matches ACGT exactly; the flag must stay set
      // while other codes push the window out of match.
      load_setting(4, 1, 1, 1, 1, 1);
      send_base(BASE_A, 1'b0);
      send_base(BASE_C, 1'b0);
      send_base(BASE_G, 1'b0);
      send_base(BASE_T, 1'b0);
      send_base(BASE_A, 1'b0);
      send_base(BASE_OTHER, 1'b0);
      send_base(BASE_OTHER + 3'd1, 1'b0);
      send_base(BASE_OTHER + 3'd2, 1'b0);
      send_base(BASE_CODE_MAX, 1'b0);
      send_base(BASE_T, 1'b1);
      send_base(BASE_G, 1'b1);

      // Window shrunk to length zero in the middle of a read, then set far
      // above the store depth before the read ends.
      send_base(BASE_A, 1'b0);
      send_base(BASE_C, 1'b0);
      send_base(BASE_G, 1'b0);
      drain_results();
      load_setting(0, 0, 1, 0, 0, 1);
      send_base(BASE_C, 1'b0);
      send_base(BASE_A, 1'b0);
      drain_results();
      load_setting(127, 1, 1, 1, 1, 255);
      send_base(BASE_T, 1'b1);

      // Random reads under a series of settings, extremes first.
      random_goal = bases_sent + RANDOM_BASES;
      phase = 0;
      while (bases_sent < random_goal) begin
         drain_results();
         case (phase)
            0: load_setting(1, 1, 0, 0, 0, 1);
            1: load_setting(64, 16, 16, 16, 16, 12);
            2: load_setting(0, 0, 0, 0, 1, 2);
            3: load_setting(127, 64, 0, 0, 0, 255);
            4: load_setting(64, 127, 127, 127, 127, 255);
            5: load_setting(20, 5, 5, 5, 5, 0);
            6: load_setting(64, 0, 64, 0, 0, 129);
            default: begin
               span = $urandom_range(1, WINDOW_SLOTS);
               qa = $urandom_range(span);
               qc = $urandom_range(span - qa);
               qg = $urandom_range(span - qa - qc);
               limit = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(16);
               load_setting(span, qa, qc, qg, span - qa - qc - qg, limit);
            end
         endcase
         // One whole phase runs with neither side idling.
         steady_traffic <= (phase == 3);
         span_used = (sb.window_length == 0) ? 1 :
                     (sb.window_length > WINDOW_SLOTS) ? WINDOW_SLOTS : sb.window_length;
         repeat ($urandom_range(2, 3))
            stream_read($urandom_range(1, span_used + 16), $urandom_range(99) < 15,
                        $urandom_range(9) != 0);
         phase++;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.awaited_verdicts.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
